// ===== rtl/fwk_pkg.sv =====
// Shared types and constants for the Fenwick range-sum store.
package fwk_pkg;

  localparam int IDX_W    = 10;
  localparam int DATA_W   = 32;
  localparam int LEN_W    = 11;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 2;

  localparam logic [ADDR_W-1:0] REG_ARRAY_LENGTH   = 2'd0;
  localparam logic [LEN_W-1:0]  ARRAY_LENGTH_RESET = 11'd1024;

  typedef enum logic [0:0] {
    CMD_SET   = 1'b0,
    CMD_RANGE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ORDER = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD_OLD,
    S_UPD_DELTA,
    S_UPD_RD,
    S_UPD_WR,
    S_QRY_A,
    S_QRY_B,
    S_FIN
  } state_t;

  typedef struct packed {
    cmd_t                     command;
    logic [IDX_W-1:0]         element_index;
    logic signed [DATA_W-1:0] new_value;
    logic [IDX_W-1:0]         range_left;
    logic [IDX_W-1:0]         range_right;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_sum;
    status_t                  status;
  } result_t;

endpackage

// ===== rtl/fwk_engine.sv =====
// Command sequencer with the tree and element memories and their walk logic.
module fwk_engine #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [fwk_pkg::LEN_W-1:0] array_length,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  fwk_pkg::item_t           item,
  output logic                     res_valid,
  input  logic                     res_ready,
  output fwk_pkg::result_t         res
);
  import fwk_pkg::*;

  localparam int AW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int NDW = (($clog2(MAX_ELEMENTS + 1) > LEN_W) ?
                        $clog2(MAX_ELEMENTS + 1) : LEN_W) + 1;

  logic [DATA_W-1:0] tree_mem [MAX_ELEMENTS];
  logic [DATA_W-1:0] val_mem  [MAX_ELEMENTS];

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  item_t             item_r, item_nxt;
  logic [NDW-1:0]    node_r, node_nxt;
  logic [DATA_W-1:0] delta_r, delta_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  status_t           status_r, status_nxt;
  logic              rd_valid_r, rd_valid_nxt;
  logic              rd_sub_r, rd_sub_nxt;

  logic [DATA_W-1:0] tree_rd_r, val_rd_r;
  logic              tree_we, tree_re, val_we, val_re;
  logic [AW-1:0]     tree_waddr, tree_raddr, val_waddr, val_raddr;
  logic [DATA_W-1:0] tree_wdata, val_wdata;

  logic [NDW-1:0]    len_w, node_low, node_m1;

  assign len_w = (NDW'(array_length) > NDW'(MAX_ELEMENTS)) ?
                 NDW'(MAX_ELEMENTS) : NDW'(array_length);
  assign node_low = node_r & (~node_r + NDW'(1));
  assign node_m1  = node_r - NDW'(1);

  always_ff @(posedge clk) begin
    if (tree_we) tree_mem[tree_waddr] <= tree_wdata;
    if (tree_re) tree_rd_r <= tree_mem[tree_raddr];
    if (val_we) val_mem[val_waddr] <= val_wdata;
    if (val_re) val_rd_r <= val_mem[val_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      rd_valid_r <= rd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    node_r   <= node_nxt;
    delta_r  <= delta_nxt;
    acc_r    <= acc_nxt;
    status_r <= status_nxt;
    rd_sub_r <= rd_sub_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    item_nxt     = item_r;
    node_nxt     = node_r;
    delta_nxt    = delta_r;
    status_nxt   = status_r;
    rd_valid_nxt = 1'b0;
    rd_sub_nxt   = rd_sub_r;
    acc_nxt      = acc_r;
    tree_we      = 1'b0;
    tree_re      = 1'b0;
    val_we       = 1'b0;
    val_re       = 1'b0;
    tree_waddr   = AW'(node_m1);
    tree_raddr   = AW'(node_m1);
    tree_wdata   = tree_rd_r + delta_r;
    val_waddr    = AW'(item_r.element_index);
    val_raddr    = AW'(item_r.element_index);
    val_wdata    = item_r.new_value;
    item_ready   = 1'b0;
    res_valid    = 1'b0;

    if (rd_valid_r) begin
      acc_nxt = rd_sub_r ? (acc_r - tree_rd_r) : (acc_r + tree_rd_r);
    end

    case (state_r)
      S_CLEAR: begin
        tree_we    = 1'b1;
        val_we     = 1'b1;
        tree_waddr = clr_r;
        val_waddr  = clr_r;
        tree_wdata = '0;
        val_wdata  = '0;
        clr_nxt    = clr_r + AW'(1);
        if (clr_r == AW'(MAX_ELEMENTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          item_nxt   = item;
          acc_nxt    = '0;
          status_nxt = ST_OK;
          if (item.command == CMD_SET) begin
            if (NDW'(item.element_index) >= len_w) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_FIN;
            end else begin
              node_nxt  = NDW'(item.element_index) + NDW'(1);
              state_nxt = S_UPD_OLD;
            end
          end else begin
            if (NDW'(item.range_left) >= len_w || NDW'(item.range_right) >= len_w) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_FIN;
            end else if (item.range_left > item.range_right) begin
              status_nxt = ST_ORDER;
              state_nxt  = S_FIN;
            end else begin
              node_nxt  = NDW'(item.range_right) + NDW'(1);
              state_nxt = S_QRY_A;
            end
          end
        end
      end
      S_UPD_OLD: begin
        val_re    = 1'b1;
        state_nxt = S_UPD_DELTA;
      end
      S_UPD_DELTA: begin
        delta_nxt = item_r.new_value - val_rd_r;
        val_we    = 1'b1;
        state_nxt = S_UPD_RD;
      end
      S_UPD_RD: begin
        if (node_r != '0 && node_r <= len_w) begin
          tree_re   = 1'b1;
          state_nxt = S_UPD_WR;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_UPD_WR: begin
        tree_we   = 1'b1;
        node_nxt  = node_r + node_low;
        state_nxt = S_UPD_RD;
      end
      S_QRY_A: begin
        if (node_r != '0) begin
          tree_re      = 1'b1;
          rd_valid_nxt = 1'b1;
          rd_sub_nxt   = 1'b0;
          node_nxt     = node_r - node_low;
        end else begin
          node_nxt  = NDW'(item_r.range_left);
          state_nxt = S_QRY_B;
        end
      end
      S_QRY_B: begin
        if (node_r != '0) begin
          tree_re      = 1'b1;
          rd_valid_nxt = 1'b1;
          rd_sub_nxt   = 1'b1;
          node_nxt     = node_r - node_low;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.range_sum = acc_r;
  assign res.status    = status_r;

endmodule

// ===== rtl/fenwick_range_sum_store.sv =====
// Top level of the Fenwick range-sum store: configuration port and result register.
//
// Items arrive on the in_ stream: tuser carries the command (set or range
// query) and tdata the index, the new value and the range bounds. Every item
// yields exactly one result on the out_ stream: the wrapped range sum in tdata
// and a status code in tuser (ok, index beyond length, left above right).
// The user must write the element count through the APB-style cfg_ port only
// while the block is idle; the block itself does not enforce this.
// A set reads the old element value, then forms the delta and writes the new
// value, then walks the tree nodes that it touches (up to 11 for 1024
// elements); each node costs a read and a write of the tree memory. A query
// makes one tree read per node of the two prefix walks a and b (up to 10
// each) and closes each walk with a step of its own. A flagged item goes
// straight to its result. The next item is taken in the cycle after the result
// leaves the sequencer; one item is worked on at a time.
// After reset, a clearing sweep zeroes all MAX_ELEMENTS entries of both memories
// and in_tready stays low meanwhile; array_length returns to 1024.
// A finished result waits in an output register, so the next item is taken
// while out_tready is low; a second result then waits until the first leaves.
module fenwick_range_sum_store #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // element_index[9:0], new_value[41:10], range_left[51:42], range_right[61:52]
  input  logic [63:0]                  in_tdata,
  // command[0]
  input  logic [0:0]                   in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // range_sum[31:0]
  output logic [31:0]                  out_tdata,
  // status[1:0]
  output logic [1:0]                   out_tuser,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [fwk_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import fwk_pkg::*;

  logic [LEN_W-1:0]  array_length_r, array_length_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r, out_res_nxt;
  item_t             item;
  logic              res_valid, res_ready;
  result_t           res;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == REG_ARRAY_LENGTH) ?
                      {{(32 - LEN_W){1'b0}}, array_length_r} : 32'd0;

  always_comb begin
    array_length_nxt = array_length_r;
    if (cfg_wr && cfg_paddr == REG_ARRAY_LENGTH) begin
      array_length_nxt = cfg_pwdata[LEN_W-1:0];
    end
  end

  assign item.command       = cmd_t'(in_tuser[0]);
  assign item.element_index = in_tdata[9:0];
  assign item.new_value     = in_tdata[41:10];
  assign item.range_left    = in_tdata[51:42];
  assign item.range_right   = in_tdata[61:52];

  fwk_engine #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .array_length (array_length_r),
    .item_valid   (in_tvalid),
    .item_ready   (in_tready),
    .item         (item),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      array_length_r <= ARRAY_LENGTH_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      array_length_r <= array_length_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.range_sum;
  assign out_tuser  = out_res_r.status;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted in two consecutive cycles");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == 32'd0)
    else $error("flagged result carries a nonzero sum");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready before the clearing sweep");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the Fenwick range-sum store with a scoreboard class.
`timescale 1ns / 1ps

module tb;
  import fwk_pkg::*;

  localparam int NODES      = 1024;
  localparam int IDLE_LIMIT = 5000;

  // Mirrors the tree and element copies and holds the range sums still to come.
  class range_sum_board;
    logic [DATA_W-1:0] node_sums [NODES];
    logic [DATA_W-1:0] elem_vals [NODES];
    logic [LEN_W-1:0]  length_reg;
    result_t           sums_due [$];
    int                fail_count;

    function new();
      for (int i = 0; i < NODES; i++) begin
        node_sums[i] = '0;
        elem_vals[i] = '0;
      end
      length_reg = ARRAY_LENGTH_RESET;
      fail_count = 0;
    endfunction

    function void set_length(logic [LEN_W-1:0] v);
      length_reg = v;
    endfunction

    function int unsigned live_length();
      return (length_reg > NODES) ? NODES : length_reg;
    endfunction

    function logic [DATA_W-1:0] prefix_sum(int unsigned count);
      logic [DATA_W-1:0] acc;
      int unsigned       node;
      acc  = '0;
      node = count;
      while (node > 0) begin
        acc  = acc + node_sums[node-1];
        node = node - (node & (~node + 1));
      end
      return acc;
    endfunction

    function void note_item(item_t it);
      result_t           res;
      int unsigned       len;
      int unsigned       node;
      logic [DATA_W-1:0] delta;
      len        = live_length();
      res.range_sum = '0;
      res.status = ST_OK;
      if (it.command == CMD_SET) begin
        if (it.element_index >= len) begin
          res.status = ST_RANGE;
        end else begin
          delta = it.new_value - elem_vals[it.element_index];
          node  = it.element_index + 1;
          while (node <= len) begin
            node_sums[node-1] = node_sums[node-1] + delta;
            node = node + (node & (~node + 1));
          end
          elem_vals[it.element_index] = it.new_value;
        end
      end else begin
        if (it.range_left >= len || it.range_right >= len) begin
          res.status = ST_RANGE;
        end else if (it.range_left > it.range_right) begin
          res.status = ST_ORDER;
        end else begin
          res.range_sum = prefix_sum(it.range_right + 1) - prefix_sum(it.range_left);
        end
      end
      sums_due.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
    endtask

    task check_result(logic [DATA_W-1:0] sum, logic [STATUS_W-1:0] st);
      result_t want;
      if (sums_due.size() == 0) begin
        report_mismatch($sformatf("unexpected item sum=%h status=%0d", sum, st));
      end else begin
        want = sums_due.pop_front();
        if (sum !== want.range_sum)
          report_mismatch($sformatf("range_sum %h, expected %h", sum, want.range_sum));
        if (st !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  // element_index[9:0], new_value[41:10], range_left[51:42], range_right[61:52]
  logic [63:0]         in_tdata;
  // command[0]
  logic [0:0]          in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  // range_sum[31:0]
  logic [31:0]         out_tdata;
  // status[1:0]
  logic [1:0]          out_tuser;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  range_sum_board board;
  bit             no_gaps;
  int             quiet_cycles;

  fenwick_range_sum_store u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata, out_tuser);
    out_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("fenwick_range_sum_store test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t set_item(int unsigned idx, logic [DATA_W-1:0] val);
    item_t it;
    it.command       = CMD_SET;
    it.element_index = IDX_W'(idx);
    it.new_value     = val;
    it.range_left    = IDX_W'($urandom_range(0, NODES - 1));
    it.range_right   = IDX_W'($urandom_range(0, NODES - 1));
    return it;
  endfunction

  function automatic item_t query_item(int unsigned left, int unsigned right);
    item_t it;
    it.command       = CMD_RANGE;
    it.element_index = IDX_W'($urandom_range(0, NODES - 1));
    it.new_value     = $urandom;
    it.range_left    = IDX_W'(left);
    it.range_right   = IDX_W'(right);
    return it;
  endfunction

  // Mostly in-range sets and well-ordered queries; the rest is spread over all indexes.
  function automatic item_t random_item(int unsigned len);
    int unsigned l;
    bit          in_bounds;
    in_bounds = (len > 0) && ($urandom_range(0, 99) < 85);
    if ($urandom_range(0, 1) == 0) begin
      if (in_bounds)
        return set_item($urandom_range(0, len - 1), pick_value());
      return set_item($urandom_range(0, NODES - 1), pick_value());
    end
    if (in_bounds) begin
      l = $urandom_range(0, len - 1);
      return query_item(l, $urandom_range(l, len - 1));
    end
    return query_item($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1));
  endfunction

  task automatic send_item(input item_t it);
    while (!no_gaps && $urandom_range(0, 99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.command;
    in_tdata  <= {2'b00, it.range_right, it.range_left, it.new_value, it.element_index};
    do @(posedge clk); while (!in_tready);
    board.note_item(it);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.sums_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    board.set_length(data[LEN_W-1:0]);
  endtask

  task automatic random_phase(input int unsigned len, input int count, input bit steady);
    drain();
    cfg_write(REG_ARRAY_LENGTH, len);
    no_gaps = steady;
    for (int i = 0; i < count; i++) begin
      send_item(random_item(board.live_length()));
      if (i == count / 2 && len == NODES)
        drain();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    board        = new();
    clk          = 1'b0;
    no_gaps      = 1'b0;
    quiet_cycles = 0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!in_tready);

    cfg_write(REG_ARRAY_LENGTH, NODES);
    send_item(set_item(0, 32'h7fff_ffff));
    send_item(set_item(1023, 32'h8000_0000));
    send_item(set_item(512, 32'hffff_ffff));
    send_item(set_item(511, 32'h0000_0001));
    send_item(set_item(0, 32'h0000_0005));
    send_item(query_item(0, 1023));
    send_item(query_item(0, 0));
    send_item(query_item(1023, 1023));
    send_item(query_item(511, 512));
    send_item(query_item(1, 1022));
    send_item(query_item(600, 3));
    send_item(query_item(1023, 0));

    drain();
    cfg_write(REG_ARRAY_LENGTH, 8);
    send_item(set_item(8, 32'h0000_0009));
    send_item(set_item(7, 32'h0000_0064));
    send_item(query_item(0, 7));
    send_item(query_item(9, 2));
    send_item(query_item(3, 8));
    send_item(query_item(5, 4));
    send_item(query_item(0, 0));

    drain();
    cfg_write(REG_ARRAY_LENGTH, 0);
    send_item(set_item(0, 32'h1234_5678));
    send_item(query_item(0, 0));

    drain();
    cfg_write(REG_ARRAY_LENGTH, 2047);
    send_item(query_item(0, 1023));
    send_item(set_item(1023, 32'h0000_0003));
    send_item(query_item(1000, 1023));

    random_phase(NODES, 120, 1'b0);
    random_phase(37, 60, 1'b0);
    random_phase(2047, 80, 1'b1);
    random_phase(1, 30, 1'b0);
    random_phase(0, 10, 1'b0);
    random_phase(300, 50, 1'b0);
    random_phase(NODES, 50, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    if (board.fail_count == 0 && board.sums_due.size() == 0) begin
      $display("fenwick_range_sum_store test passed");
    end else begin
      $display("fenwick_range_sum_store test failed");
    end
    $finish;
  end

endmodule

// ===== fenwick_range_sum_store.f =====
rtl/fwk_pkg.sv
rtl/fwk_engine.sv
rtl/fenwick_range_sum_store.sv
tb/tb.sv
